### hdl/spwm_pkg.sv
package spwm_pkg;

  localparam int unsigned PhaseBits    = 32;
  localparam int unsigned PeriodBits   = 16;
  localparam int unsigned AmpBits      = 11;
  localparam int unsigned CmpBits      = 16;
  localparam int unsigned TableEntries = 512;
  localparam int unsigned IndexBits    = $clog2(TableEntries);
  localparam int unsigned QuarterEntries = TableEntries >> 1;
  localparam int unsigned ScaleBits    = 12;
  localparam int unsigned TableScale   = 1 << ScaleBits;
  localparam int unsigned AmpShift     = 10;
  localparam int unsigned SineBits     = ScaleBits + 1;
  localparam int unsigned AccBits      = SineBits + PeriodBits;
  localparam int unsigned CntBits      = $clog2(PhaseBits);
  localparam int unsigned CfgIdxBits   = 8;

  localparam logic [PhaseBits-1:0]  StepReset   = 32'd42949650;
  localparam logic [PeriodBits-1:0] PeriodReset = 16'd1600;

  localparam logic [CfgIdxBits-1:0] RegPhaseStep   = 8'd0;
  localparam logic [CfgIdxBits-1:0] RegTimerPeriod = 8'd1;

  localparam logic [63:0] PiQ62  = 64'hC90FDAA22168C234;
  localparam logic [63:0] PiStep = PiQ62 / 64'(TableEntries);
  localparam logic [63:0] PiRem  = PiQ62 % 64'(TableEntries);

  typedef logic [SineBits-1:0] quarter_rom_t [QuarterEntries];

  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Fixed-point Taylor series of sin(i*pi/N), rounded to the table scale.
  function automatic logic [SineBits-1:0] sine_entry(int unsigned i);
    logic [63:0] k;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] t;
    logic [63:0] n;
    k = 64'(i);
    if (2 * k > 64'(TableEntries)) begin
      k = 64'(TableEntries) - k;
    end
    x = PiStep * k + ((PiRem * k) >> IndexBits);
    term = x;
    sum  = x;
    n    = 64'd1;
    while (term != 64'd0 && n < 64'd60) begin
      term = div_u64(mul_q62(mul_q62(term, x), x), (n + 64'd1) * (n + 64'd2));
      if ((((n - 64'd1) >> 1) & 64'd1) == 64'd0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
      n = n + 64'd2;
    end
    t = mul_q62(sum, 64'(2 * TableScale));
    t = (t + 64'd1) >> 1;
    return t[SineBits-1:0];
  endfunction

  function automatic quarter_rom_t build_quarter_rom();
    quarter_rom_t r;
    for (int unsigned i = 0; i < QuarterEntries; i++) begin
      r[i] = sine_entry(i);
    end
    return r;
  endfunction

  localparam quarter_rom_t QuarterRom = build_quarter_rom();
  localparam logic [SineBits-1:0] SinePeak = sine_entry(QuarterEntries);

endpackage

### hdl/spwm_phase_accumulator_top.sv
// Channel   Direction  Word contents
// s_axis    in         tdata[10:0] amplitude
// m_axis    out        tdata[15:0] compare value, tuser[0] channel A active, tuser[1] sync
// cfg       in         index 0 phase step, index 1 timer period
//
// An accepted input word passes these steps in order: the phase add runs one bit per
// cycle, then the table step, the two shift-and-add multiplies of the 16-bit period
// and the 11-bit amplitude, and the hand-off step, which waits while the output is stalled.
// A new input word is taken only after the hand-off, when the block is idle again.
// A stalled output holds its word while the next input word is worked on.
// Reset is asynchronous and active low and leaves channel A active.
module spwm_phase_accumulator_top
  import spwm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,    // [10:0] amplitude
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,    // [15:0] compare_value
  output logic [1:0]            m_axis_tuser,    // [0] channel_a_active, [1] sync_level
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [PhaseBits-1:0]  cfg_data_i
);

  typedef enum logic [2:0] {
    StIdle,
    StAdd,
    StRom,
    StMulP,
    StMulA,
    StDone
  } state_e;

  state_e                state_q;
  logic [PhaseBits-1:0]  phase_step_q;
  logic [PeriodBits-1:0] timer_period_q;
  logic [PhaseBits-1:0]  phase_q;
  logic [PhaseBits-1:0]  step_sh_q;
  logic                  carry_q;
  logic [CntBits-1:0]    bit_cnt_q;
  logic [AmpBits-1:0]    amp_q;
  logic [AccBits-1:0]    mcand_q;
  logic [PeriodBits-1:0] mplier_q;
  logic [AccBits-1:0]    acc_q;
  logic                  prev_top_q;
  logic                  swap_q;
  logic                  ind_q;
  logic                  chan_q;
  logic                  out_valid_q;
  logic [CmpBits-1:0]    out_cmp_q;
  logic                  out_chan_q;
  logic                  out_ind_q;

  logic                  sum_bit;
  logic                  carry_d;
  logic                  top_bit;
  logic [AccBits-1:0]    acc_d;
  logic [CmpBits:0]      cmp_full;
  logic [IndexBits-1:0]  rom_idx;
  logic [IndexBits-1:0]  fold_idx;
  logic [SineBits-1:0]   sine_val;

  assign s_axis_tready = (state_q == StIdle);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_cmp_q;
  assign m_axis_tuser  = {out_ind_q, out_chan_q};

  assign sum_bit  = phase_q[0] ^ step_sh_q[0] ^ carry_q;
  assign carry_d  = (phase_q[0] & step_sh_q[0]) | (carry_q & (phase_q[0] ^ step_sh_q[0]));
  assign top_bit  = phase_q[PhaseBits-1];
  assign acc_d    = mplier_q[0] ? acc_q + mcand_q : acc_q;
  assign cmp_full = acc_q[AmpShift +: CmpBits + 1];

  // The half-sine table is symmetric, so only its first half is stored.
  assign rom_idx  = phase_q[PhaseBits-1 -: IndexBits];
  assign fold_idx = rom_idx[IndexBits-1] ? (~rom_idx + IndexBits'(1)) : rom_idx;
  assign sine_val = fold_idx[IndexBits-1] ? SinePeak : QuarterRom[fold_idx[IndexBits-2:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      phase_step_q   <= StepReset;
      timer_period_q <= PeriodReset;
      phase_q        <= '0;
      step_sh_q      <= '0;
      amp_q          <= '0;
      mcand_q        <= '0;
      mplier_q       <= '0;
      acc_q          <= '0;
      prev_top_q     <= 1'b0;
      swap_q         <= 1'b0;
      ind_q          <= 1'b0;
      chan_q         <= 1'b1;
      out_valid_q    <= 1'b0;
      out_cmp_q      <= '0;
      out_chan_q     <= 1'b0;
      out_ind_q      <= 1'b0;
      bit_cnt_q      <= '0;
      carry_q        <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == RegPhaseStep) begin
          phase_step_q <= cfg_data_i;
        end else if (cfg_index_i == RegTimerPeriod) begin
          timer_period_q <= cfg_data_i[PeriodBits-1:0];
        end
      end
      if (out_valid_q && m_axis_tready && state_q != StDone) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            amp_q     <= s_axis_tdata[AmpBits-1:0];
            step_sh_q <= phase_step_q;
            carry_q   <= 1'b0;
            bit_cnt_q <= '0;
            state_q   <= StAdd;
          end
        end
        StAdd: begin
          phase_q   <= {sum_bit, phase_q[PhaseBits-1:1]};
          step_sh_q <= step_sh_q >> 1;
          carry_q   <= carry_d;
          bit_cnt_q <= bit_cnt_q + 1'b1;
          if (bit_cnt_q == CntBits'(PhaseBits - 1)) begin
            state_q <= StRom;
          end
        end
        StRom: begin
          if (swap_q) begin
            chan_q <= ~chan_q;
            swap_q <= 1'b0;
          end else if (prev_top_q && !top_bit) begin
            swap_q <= 1'b1;
            ind_q  <= ~ind_q;
          end
          prev_top_q <= top_bit;
          mcand_q    <= AccBits'(sine_val);
          mplier_q   <= timer_period_q;
          acc_q      <= '0;
          bit_cnt_q  <= '0;
          state_q    <= StMulP;
        end
        StMulP: begin
          if (bit_cnt_q == CntBits'(PeriodBits - 1)) begin
            mcand_q   <= AccBits'(acc_d[ScaleBits +: CmpBits]);
            mplier_q  <= PeriodBits'(amp_q);
            acc_q     <= '0;
            bit_cnt_q <= '0;
            state_q   <= StMulA;
          end else begin
            mcand_q   <= mcand_q << 1;
            mplier_q  <= mplier_q >> 1;
            acc_q     <= acc_d;
            bit_cnt_q <= bit_cnt_q + 1'b1;
          end
        end
        StMulA: begin
          acc_q <= acc_d;
          if (bit_cnt_q == CntBits'(AmpBits - 1)) begin
            bit_cnt_q <= '0;
            state_q   <= StDone;
          end else begin
            mcand_q   <= mcand_q << 1;
            mplier_q  <= mplier_q >> 1;
            bit_cnt_q <= bit_cnt_q + 1'b1;
          end
        end
        StDone: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_cmp_q   <= cmp_full[CmpBits] ? '1 : cmp_full[CmpBits-1:0];
            out_chan_q  <= chan_q;
            out_ind_q   <= ind_q;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  a_accept_starts_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q == StAdd)
    else $error("accepted word did not start the phase add");

  a_swap_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRom && swap_q |=> !swap_q && chan_q != $past(chan_q))
    else $error("pending swap was not carried out");

  a_sync_arms_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ind_q != $past(ind_q) |-> swap_q)
    else $error("sync toggled without arming a swap");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> out_valid_q && $stable(out_cmp_q))
    else $error("stalled result word was overwritten");

endmodule

### bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spwm_pkg::*;

  localparam int unsigned CycleLimit    = 2_000_000;
  localparam int unsigned LatencyCycles = 61;
  localparam int unsigned RandomWords   = 1150;
  localparam int unsigned ReportLimit   = 10;

  localparam logic [CfgIdxBits-1:0] RegUnmapped = 8'hA5;

  typedef struct packed {
    logic [CmpBits-1:0] cmp;
    logic               chan_a;
    logic               sync;
  } pwm_word_t;

  typedef enum logic {RowCfg, RowWord} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CfgIdxBits-1:0] reg_idx;
    logic [PhaseBits-1:0]  reg_val;
    logic [AmpBits-1:0]    amp;
    logic                  typed;
    pwm_word_t             typed_word;
  } stim_row_t;

  typedef enum logic [1:0] {RxOpen, RxRandom, RxBlocks} rx_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [15:0]           m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxBits-1:0] cfg_index_i = '0;
  logic [PhaseBits-1:0]  cfg_data_i = '0;

  spwm_phase_accumulator_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  logic [SineBits-1:0]   half_sine_tbl [TableEntries];
  logic [PhaseBits-1:0]  step_q;
  logic [PeriodBits-1:0] period_q;
  logic [PhaseBits-1:0]  phase_q;
  logic                  prev_top_q;
  logic                  swap_armed_q;
  logic                  sync_q;
  logic                  chan_a_q;

  pwm_word_t   pending_words [$];
  stim_row_t   directed_rows [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned words_sent = 0;
  pwm_word_t   seen_word;
  pwm_word_t   due_word;

  rx_mode_e    rx_mode = RxOpen;
  int unsigned rx_left = 0;
  int unsigned rx_phase = 0;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // The output side switches at random between open, random and blocked stall patterns.
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_left = $urandom_range(50, 600);
      rx_phase = 0;
    end else begin
      rx_left--;
    end
    rx_phase = (rx_phase == 79) ? 0 : rx_phase + 1;
    case (rx_mode)
      RxOpen:   m_axis_tready = 1'b1;
      RxRandom: m_axis_tready = ($urandom_range(0, 3) != 0);
      default:  m_axis_tready = (rx_phase >= 25);
    endcase
  end

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) begin
      $display("%s: expected cmp=%0d chan_a=%0b sync=%0b, got cmp=%0d chan_a=%0b sync=%0b",
               what, due_word.cmp, due_word.chan_a, due_word.sync,
               seen_word.cmp, seen_word.chan_a, seen_word.sync);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_word.cmp    = m_axis_tdata;
      seen_word.chan_a = m_axis_tuser[0];
      seen_word.sync   = m_axis_tuser[1];
      if (pending_words.size() == 0) begin
        due_word = '0;
        note_mismatch("unexpected output word");
      end else begin
        due_word = pending_words.pop_front();
        if (seen_word.cmp !== due_word.cmp || seen_word.chan_a !== due_word.chan_a ||
            seen_word.sync !== due_word.sync) begin
          note_mismatch("output word mismatch");
        end
      end
    end
  end

  task automatic advance_phase(input logic [AmpBits-1:0] amp, output pwm_word_t word);
    logic                 top;
    logic [IndexBits-1:0] idx;
    logic [63:0]          scaled;
    phase_q = phase_q + step_q;
    top = phase_q[PhaseBits-1];
    if (swap_armed_q) begin
      chan_a_q = ~chan_a_q;
      swap_armed_q = 1'b0;
    end else if (prev_top_q && !top) begin
      swap_armed_q = 1'b1;
      sync_q = ~sync_q;
    end
    prev_top_q = top;
    idx = phase_q[PhaseBits-1 -: IndexBits];
    scaled = (64'(half_sine_tbl[idx]) * 64'(period_q)) >> ScaleBits;
    scaled = (scaled * 64'(amp)) >> AmpShift;
    word.cmp = (scaled > 64'hFFFF) ? 16'hFFFF : scaled[CmpBits-1:0];
    word.chan_a = chan_a_q;
    word.sync = sync_q;
  endtask

  task automatic send_amp(input logic [AmpBits-1:0] amp, input logic typed,
                          input pwm_word_t typed_word);
    pwm_word_t word;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = 16'(amp);
    do @(posedge clk_i); while (!s_axis_tready);
    advance_phase(amp, word);
    pending_words.push_back(typed ? typed_word : word);
    words_sent++;
  endtask

  task automatic hold_off(input int unsigned cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      s_axis_tdata = 16'($urandom);
      repeat (cycles - 1) begin
        @(negedge clk_i);
        s_axis_tdata = 16'($urandom);
      end
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [PhaseBits-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == RegPhaseStep) begin
      step_q = val;
    end else if (idx == RegTimerPeriod) begin
      period_q = val[PeriodBits-1:0];
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic add_cfg(input logic [CfgIdxBits-1:0] idx, input logic [PhaseBits-1:0] val);
    stim_row_t row;
    row = '0;
    row.kind = RowCfg;
    row.reg_idx = idx;
    row.reg_val = val;
    directed_rows.push_back(row);
  endtask

  task automatic add_word(input logic [AmpBits-1:0] amp, input logic typed,
                          input pwm_word_t typed_word);
    stim_row_t row;
    row = '0;
    row.kind = RowWord;
    row.amp = amp;
    row.typed = typed;
    row.typed_word = typed_word;
    directed_rows.push_back(row);
  endtask

  function automatic logic [AmpBits-1:0] pick_amp();
    case ($urandom_range(0, 19))
      0:       return '0;
      1, 2:    return 11'd1024;
      3, 4, 5,
      6, 7:    return AmpBits'($urandom_range(0, 2047));
      default: return AmpBits'($urandom_range(0, 1024));
    endcase
  endfunction

  function automatic logic [PhaseBits-1:0] pick_step();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000 ^ 32'($urandom_range(0, 15));
      3, 4, 5: return $urandom;
      default: return 32'($urandom_range(1, 32'h0400_0000));
    endcase
  endfunction

  function automatic logic [PhaseBits-1:0] pick_period();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'd1;
      2:       return 32'd65535;
      3:       return 32'(PeriodReset);
      default: return 32'($urandom_range(1, 65535));
    endcase
  endfunction

  initial begin
    pwm_word_t   idle_word;
    stim_row_t   row;
    int unsigned block_words;

    for (int unsigned i = 0; i < TableEntries; i++) begin
      half_sine_tbl[i] = sine_entry(i);
    end
    step_q = StepReset;
    period_q = PeriodReset;
    phase_q = '0;
    prev_top_q = 1'b0;
    swap_armed_q = 1'b0;
    sync_q = 1'b0;
    chan_a_q = 1'b1;

    // With a zero step the phase stays at zero, so the table entry and the
    // compare value are zero and channel A stays active.
    idle_word.cmp = '0;
    idle_word.chan_a = 1'b1;
    idle_word.sync = 1'b0;
    add_cfg(RegPhaseStep, 32'd0);
    add_word(11'd2047, 1'b1, idle_word);
    add_word(11'd0, 1'b1, idle_word);
    add_cfg(RegPhaseStep, 32'h0080_0000);
    add_word(11'd1024, 1'b0, '0);
    add_word(11'd2047, 1'b0, '0);
    add_word(11'd1, 1'b0, '0);
    add_cfg(RegTimerPeriod, 32'd65535);
    add_cfg(RegPhaseStep, 32'h4000_0000);
    add_word(11'd2047, 1'b0, '0);
    add_word(11'd2047, 1'b0, '0);
    add_word(11'd1024, 1'b0, '0);
    add_word(11'd1024, 1'b0, '0);
    add_cfg(RegTimerPeriod, 32'd1);
    add_word(11'd1024, 1'b0, '0);
    add_word(11'd2047, 1'b0, '0);
    add_cfg(RegTimerPeriod, 32'd0);
    add_word(11'd2047, 1'b0, '0);
    add_cfg(RegUnmapped, 32'hFFFF_FFFF);
    add_cfg(RegTimerPeriod, 32'(PeriodReset));
    add_cfg(RegPhaseStep, 32'h8000_0000);
    add_word(11'd1024, 1'b0, '0);
    add_word(11'd1024, 1'b0, '0);
    add_word(11'd1024, 1'b0, '0);
    add_word(11'd1024, 1'b0, '0);
    add_cfg(RegPhaseStep, 32'hFFFF_FFFF);
    add_word(11'd1024, 1'b0, '0);
    add_word(11'd1024, 1'b0, '0);
    add_word(11'h2AA, 1'b0, '0);
    add_word(11'h555, 1'b0, '0);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == RowCfg) begin
        settle();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        send_amp(row.amp, row.typed, row.typed_word);
      end
    end

    words_sent = 0;
    while (words_sent < RandomWords) begin
      settle();
      write_reg(RegPhaseStep, pick_step());
      if ($urandom_range(0, 9) < 7) begin
        write_reg(RegTimerPeriod, pick_period());
      end
      if ($urandom_range(0, 19) == 0) begin
        write_reg(RegUnmapped, $urandom);
      end
      block_words = $urandom_range(40, 150);
      repeat (block_words) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90));
        end
        send_amp(pick_amp(), 1'b0, '0);
        burst_left--;
      end
    end

    settle();
    repeat (LatencyCycles + 10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
